// ===== sv/bpp_pkg.sv =====
// Shared types and constants for the B+tree page parser.
`timescale 1ns / 1ps

package bpp_pkg;

  // Walk position within the page
  typedef enum logic [3:0] {
    PH_MAGIC  = 4'd0,
    PH_COUNT  = 4'd1,
    PH_HEIGHT = 4'd2,
    PH_PREFIX = 4'd3,
    PH_TSIZE  = 4'd4,
    PH_KLEN   = 4'd5,
    PH_KDATA  = 4'd6,
    PH_VLEN   = 4'd7,
    PH_VDATA  = 4'd8,
    PH_CHILD  = 4'd9,
    PH_PAD    = 4'd10
  } phase_e;

  // Byte label reported with each item
  typedef enum logic [3:0] {
    KIND_MAGIC   = 4'd0,
    KIND_COUNT   = 4'd1,
    KIND_HEIGHT  = 4'd2,
    KIND_PREFIX  = 4'd3,
    KIND_TSIZE   = 4'd4,
    KIND_KLEN    = 4'd5,
    KIND_KDATA   = 4'd6,
    KIND_VLEN    = 4'd7,
    KIND_VDATA   = 4'd8,
    KIND_CPAGE   = 4'd9,
    KIND_CLEAF   = 4'd10,
    KIND_CSIZE   = 4'd11,
    KIND_PAD     = 4'd12
  } kind_e;

  // Sticky page status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_TRUNC     = 2'd2,
    ST_BAD_PAD   = 2'd3
  } status_e;

  localparam int unsigned MagicLen     = 6;
  localparam int unsigned TsizeLen     = 8;
  localparam int unsigned ChildPageEnd = 8;
  localparam int unsigned ChildLeafEnd = 16;
  localparam int unsigned ChildLen     = 20;

  localparam logic [7:0] ROOT_MASK   = 8'h80;
  localparam logic [7:0] HEIGHT_MASK = 8'h7f;

  localparam logic [7:0] MAGIC_BYTES [8] = '{8'h4B, 8'h56, 8'h4C, 8'h44,
                                              8'h53, 8'h00, 8'h00, 8'h00};

  // Walker state carried from byte to byte
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  field_pos;
    logic [16:0] elem_cnt;
    logic [15:0] key_count;
    logic        root_flag;
    logic        leaf_flag;
    logic [7:0]  bytes_left;
    status_e     err;
  } walk_state_t;

  localparam walk_state_t WALK_RESET = '{
    phase:      PH_MAGIC,
    field_pos:  8'd0,
    elem_cnt:   17'd0,
    key_count:  16'd0,
    root_flag:  1'b0,
    leaf_flag:  1'b1,
    bytes_left: 8'd0,
    err:        ST_OK
  };

  // Label for one byte
  typedef struct packed {
    kind_e       kind;
    logic [15:0] elem_index;
    logic [7:0]  elem_offset;
    logic [7:0]  data_byte;
    logic        page_end;
    status_e     status;
  } label_t;

endpackage

// ===== sv/bpp_step.sv =====
// Combinational per-byte step: next walker state and the byte's label.
`timescale 1ns / 1ps

module bpp_step (
  input  bpp_pkg::walk_state_t cur_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_i,
  output bpp_pkg::walk_state_t nxt_o,
  output bpp_pkg::label_t      label_o
);

  // After the keys: values on a leaf, children on a parent
  function automatic bpp_pkg::walk_state_t enter_vc(bpp_pkg::walk_state_t s);
    bpp_pkg::walk_state_t r;
    r = s;
    r.elem_cnt  = '0;
    r.field_pos = '0;
    if (s.leaf_flag) begin
      r.phase = (s.key_count != '0) ? bpp_pkg::PH_VLEN : bpp_pkg::PH_PAD;
    end else begin
      r.phase = bpp_pkg::PH_CHILD;
    end
    return r;
  endfunction

  // After the header: keys, or straight on when there are none
  function automatic bpp_pkg::walk_state_t enter_data(bpp_pkg::walk_state_t s);
    bpp_pkg::walk_state_t r;
    r = s;
    r.elem_cnt  = '0;
    r.field_pos = '0;
    if (s.key_count != '0) begin
      r.phase = bpp_pkg::PH_KLEN;
    end else begin
      r = enter_vc(r);
    end
    return r;
  endfunction

  function automatic bpp_pkg::walk_state_t next_key(bpp_pkg::walk_state_t s);
    bpp_pkg::walk_state_t r;
    r = s;
    r.elem_cnt = s.elem_cnt + 17'd1;
    if (r.elem_cnt >= {1'b0, s.key_count}) begin
      r = enter_vc(r);
    end else begin
      r.phase = bpp_pkg::PH_KLEN;
    end
    return r;
  endfunction

  function automatic bpp_pkg::walk_state_t next_value(bpp_pkg::walk_state_t s);
    bpp_pkg::walk_state_t r;
    r = s;
    r.elem_cnt = s.elem_cnt + 17'd1;
    r.phase = (r.elem_cnt >= {1'b0, s.key_count}) ? bpp_pkg::PH_PAD : bpp_pkg::PH_VLEN;
    return r;
  endfunction

  bpp_pkg::walk_state_t n;
  bpp_pkg::kind_e       kind;
  logic [15:0]          idx;
  logic [7:0]           off;
  logic [7:0]           fp_inc;
  bpp_pkg::status_e     err_fin;

  assign fp_inc = cur_i.field_pos + 8'd1;

  // Phase update and labeling
  always_comb begin
    n    = cur_i;
    kind = bpp_pkg::KIND_PAD;
    idx  = '0;
    off  = '0;
    case (cur_i.phase)
      bpp_pkg::PH_MAGIC: begin
        kind = bpp_pkg::KIND_MAGIC;
        off  = cur_i.field_pos;
        if (data_byte_i != bpp_pkg::MAGIC_BYTES[cur_i.field_pos[2:0]]) begin
          if (cur_i.err == bpp_pkg::ST_OK) n.err = bpp_pkg::ST_BAD_MAGIC;
          n.phase = bpp_pkg::PH_PAD;
        end else if (fp_inc >= 8'(bpp_pkg::MagicLen)) begin
          n.field_pos = '0;
          n.phase     = bpp_pkg::PH_COUNT;
        end else begin
          n.field_pos = fp_inc;
        end
      end
      bpp_pkg::PH_COUNT: begin
        kind = bpp_pkg::KIND_COUNT;
        off  = cur_i.field_pos;
        if (cur_i.field_pos == '0) begin
          n.key_count = {data_byte_i, 8'd0};
          n.field_pos = 8'd1;
        end else begin
          n.key_count = {cur_i.key_count[15:8], cur_i.key_count[7:0] | data_byte_i};
          n.field_pos = '0;
          n.phase     = bpp_pkg::PH_HEIGHT;
        end
      end
      bpp_pkg::PH_HEIGHT: begin
        kind        = bpp_pkg::KIND_HEIGHT;
        n.root_flag = (data_byte_i & bpp_pkg::ROOT_MASK) != '0;
        n.leaf_flag = (data_byte_i & bpp_pkg::HEIGHT_MASK) == '0;
        n.phase     = bpp_pkg::PH_PREFIX;
      end
      bpp_pkg::PH_PREFIX: begin
        kind = bpp_pkg::KIND_PREFIX;
        if (cur_i.root_flag) begin
          n.field_pos = '0;
          n.phase     = bpp_pkg::PH_TSIZE;
        end else begin
          n = enter_data(cur_i);
        end
      end
      bpp_pkg::PH_TSIZE: begin
        kind = bpp_pkg::KIND_TSIZE;
        off  = cur_i.field_pos;
        n.field_pos = fp_inc;
        if (fp_inc >= 8'(bpp_pkg::TsizeLen)) n = enter_data(n);
      end
      bpp_pkg::PH_KLEN, bpp_pkg::PH_VLEN: begin
        kind = (cur_i.phase == bpp_pkg::PH_KLEN) ? bpp_pkg::KIND_KLEN : bpp_pkg::KIND_VLEN;
        idx  = cur_i.elem_cnt[15:0];
        if (data_byte_i != '0) begin
          n.bytes_left = data_byte_i;
          n.field_pos  = '0;
          n.phase = (cur_i.phase == bpp_pkg::PH_KLEN) ? bpp_pkg::PH_KDATA : bpp_pkg::PH_VDATA;
        end else if (cur_i.phase == bpp_pkg::PH_KLEN) begin
          n = next_key(cur_i);
        end else begin
          n = next_value(cur_i);
        end
      end
      bpp_pkg::PH_KDATA, bpp_pkg::PH_VDATA: begin
        kind = (cur_i.phase == bpp_pkg::PH_KDATA) ? bpp_pkg::KIND_KDATA
                                                   : bpp_pkg::KIND_VDATA;
        idx  = cur_i.elem_cnt[15:0];
        off  = cur_i.field_pos;
        n.field_pos  = fp_inc;
        n.bytes_left = cur_i.bytes_left - 8'd1;
        if (n.bytes_left == '0) begin
          if (cur_i.phase == bpp_pkg::PH_KDATA) n = next_key(n);
          else                                  n = next_value(n);
        end
      end
      bpp_pkg::PH_CHILD: begin
        idx = cur_i.elem_cnt[15:0];
        if (cur_i.field_pos < 8'(bpp_pkg::ChildPageEnd)) begin
          kind = bpp_pkg::KIND_CPAGE;
          off  = cur_i.field_pos;
        end else if (cur_i.field_pos < 8'(bpp_pkg::ChildLeafEnd)) begin
          kind = bpp_pkg::KIND_CLEAF;
          off  = cur_i.field_pos - 8'(bpp_pkg::ChildPageEnd);
        end else begin
          kind = bpp_pkg::KIND_CSIZE;
          off  = cur_i.field_pos - 8'(bpp_pkg::ChildLeafEnd);
        end
        n.field_pos = fp_inc;
        if (fp_inc >= 8'(bpp_pkg::ChildLen)) begin
          n.field_pos = '0;
          n.elem_cnt  = cur_i.elem_cnt + 17'd1;
          if (n.elem_cnt > {1'b0, cur_i.key_count}) n.phase = bpp_pkg::PH_PAD;
        end
      end
      default: begin
        kind = bpp_pkg::KIND_PAD;
        if (data_byte_i != '0 && cur_i.err == bpp_pkg::ST_OK) n.err = bpp_pkg::ST_BAD_PAD;
        n.phase = bpp_pkg::PH_PAD;
      end
    endcase
  end

  // Truncation check on the final byte
  always_comb begin
    err_fin = n.err;
    if (last_i && n.phase != bpp_pkg::PH_PAD && n.err == bpp_pkg::ST_OK) begin
      err_fin = bpp_pkg::ST_TRUNC;
    end
  end

  // Final byte returns the walker to its start
  always_comb begin
    nxt_o = n;
    nxt_o.err = err_fin;
    if (last_i) nxt_o = bpp_pkg::WALK_RESET;
  end

  assign label_o = '{
    kind:        kind,
    elem_index:  idx,
    elem_offset: off,
    data_byte:   data_byte_i,
    page_end:    last_i,
    status:      err_fin
  };

endmodule

// ===== sv/btree_page_parser.sv =====
// Top level: B+tree page byte labeler with walker state and output register.
`timescale 1ns / 1ps
// An accepted input item's label is registered and shown on the output in the next cycle.
// Throughput: one item per cycle when not stalled; the walk update is one combinational step.
// The output register frees up in the cycle it is taken, so input keeps flowing.
// Reset (rst_ni low, async): walker at the start of a page, no status, output empty.

module btree_page_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [15:0] element_index, [23:16] element_offset,
                                        // [31:24] byte_out, [33:32] status, [39:34] zero
  output logic [3:0]  m_axis_tuser_o,   // [3:0] kind
  output logic        m_axis_tlast_o    // page_end
);

  bpp_pkg::walk_state_t state_q, state_d;
  bpp_pkg::label_t      label_d, label_q;
  logic                 out_valid_q;
  logic                 in_acc;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  bpp_step u_step (
    .cur_i       (state_q),
    .data_byte_i (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .nxt_o       (state_d),
    .label_o     (label_d)
  );

  // Walker state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpp_pkg::WALK_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) label_q <= label_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, label_q.status, label_q.data_byte,
                            label_q.elem_offset, label_q.elem_index};
  assign m_axis_tuser_o  = label_q.kind;
  assign m_axis_tlast_o  = label_q.page_end;

endmodule

// ===== sim/btree_page_parser_tb.sv =====
// Testbench for the B+tree page parser: random and directed pages against a predictor.
`timescale 1ns / 1ps

module btree_page_parser_tb;
  import bpp_pkg::*;

  localparam int unsigned ItemTarget = 1200;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldStart  = 600;
  localparam int unsigned HoldLen    = 250;

  typedef logic [7:0] page_t [$];

  // Predicts the label of each accepted byte and checks labels as they come out
  class byte_label_tracker;
    phase_e      ph;
    logic [7:0]  fpos;
    logic [16:0] elem;
    logic [15:0] nkeys;
    logic        is_root;
    logic        is_leaf;
    logic [7:0]  left;
    status_e     err;
    label_t      labels_due [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear_walk();
    endfunction

    function void clear_walk();
      ph      = PH_MAGIC;
      fpos    = '0;
      elem    = '0;
      nkeys   = '0;
      is_root = 1'b0;
      is_leaf = 1'b1;
      left    = '0;
      err     = ST_OK;
    endfunction

    // After the keys: values on a leaf, child records on a parent
    function void start_tail();
      elem = '0;
      fpos = '0;
      if (!is_leaf) ph = PH_CHILD;
      else if (nkeys != 0) ph = PH_VLEN;
      else ph = PH_PAD;
    endfunction

    function void start_keys();
      elem = '0;
      fpos = '0;
      if (nkeys != 0) ph = PH_KLEN;
      else start_tail();
    endfunction

    function void advance_key();
      elem = elem + 1'b1;
      if (elem >= nkeys) start_tail();
      else ph = PH_KLEN;
    endfunction

    function void advance_value();
      elem = elem + 1'b1;
      if (elem >= nkeys) ph = PH_PAD;
      else ph = PH_VLEN;
    endfunction

    function void note_byte(logic [7:0] b, logic l);
      label_t lab;
      lab.kind        = KIND_PAD;
      lab.elem_index  = '0;
      lab.elem_offset = '0;
      lab.data_byte   = b;
      lab.page_end    = l;
      case (ph)
        PH_MAGIC: begin
          lab.kind        = KIND_MAGIC;
          lab.elem_offset = fpos;
          if (b != MAGIC_BYTES[fpos[2:0]]) begin
            if (err == ST_OK) err = ST_BAD_MAGIC;
            ph = PH_PAD;
          end else begin
            fpos = fpos + 1'b1;
            if (fpos >= MagicLen) begin
              fpos = '0;
              ph   = PH_COUNT;
            end
          end
        end
        // key count arrives high byte first
        PH_COUNT: begin
          lab.kind        = KIND_COUNT;
          lab.elem_offset = fpos;
          if (fpos == 0) begin
            nkeys = {b, 8'h00};
            fpos  = 8'd1;
          end else begin
            nkeys = nkeys | {8'h00, b};
            fpos  = '0;
            ph    = PH_HEIGHT;
          end
        end
        PH_HEIGHT: begin
          lab.kind = KIND_HEIGHT;
          is_root  = (b & ROOT_MASK) != 0;
          is_leaf  = (b & HEIGHT_MASK) == 0;
          ph       = PH_PREFIX;
        end
        PH_PREFIX: begin
          lab.kind = KIND_PREFIX;
          if (is_root) begin
            fpos = '0;
            ph   = PH_TSIZE;
          end else begin
            start_keys();
          end
        end
        PH_TSIZE: begin
          lab.kind        = KIND_TSIZE;
          lab.elem_offset = fpos;
          fpos            = fpos + 1'b1;
          if (fpos >= TsizeLen) start_keys();
        end
        PH_KLEN, PH_VLEN: begin
          lab.kind       = (ph == PH_KLEN) ? KIND_KLEN : KIND_VLEN;
          lab.elem_index = elem[15:0];
          if (b != 0) begin
            left = b;
            fpos = '0;
            if (ph == PH_KLEN) ph = PH_KDATA;
            else ph = PH_VDATA;
          end else if (ph == PH_KLEN) begin
            advance_key();
          end else begin
            advance_value();
          end
        end
        PH_KDATA, PH_VDATA: begin
          lab.kind        = (ph == PH_KDATA) ? KIND_KDATA : KIND_VDATA;
          lab.elem_index  = elem[15:0];
          lab.elem_offset = fpos;
          fpos            = fpos + 1'b1;
          left            = left - 1'b1;
          if (left == 0) begin
            if (ph == PH_KDATA) advance_key();
            else advance_value();
          end
        end
        // child record: page, oldest leaf, size
        PH_CHILD: begin
          lab.elem_index = elem[15:0];
          if (fpos < ChildPageEnd) begin
            lab.kind        = KIND_CPAGE;
            lab.elem_offset = fpos;
          end else if (fpos < ChildLeafEnd) begin
            lab.kind        = KIND_CLEAF;
            lab.elem_offset = 8'(fpos - ChildPageEnd);
          end else begin
            lab.kind        = KIND_CSIZE;
            lab.elem_offset = 8'(fpos - ChildLeafEnd);
          end
          fpos = fpos + 1'b1;
          if (fpos >= ChildLen) begin
            fpos = '0;
            elem = elem + 1'b1;
            if (elem > nkeys) ph = PH_PAD;
          end
        end
        default: begin
          if (b != 0 && err == ST_OK) err = ST_BAD_PAD;
          ph = PH_PAD;
        end
      endcase
      if (l && ph != PH_PAD && err == ST_OK) err = ST_TRUNC;
      lab.status = err;
      labels_due.push_back(lab);
      if (l) clear_walk();
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_label(label_t got);
      label_t want;
      if (labels_due.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual kind %0d byte %0d",
                 $time, got.kind, got.data_byte);
        mismatches++;
        return;
      end
      want = labels_due.pop_front();
      if (got.kind !== want.kind) report("kind", want.kind, got.kind);
      if (got.elem_index !== want.elem_index)
        report("element_index", want.elem_index, got.elem_index);
      if (got.elem_offset !== want.elem_offset)
        report("element_offset", want.elem_offset, got.elem_offset);
      if (got.data_byte !== want.data_byte) report("byte_out", want.data_byte, got.data_byte);
      if (got.page_end !== want.page_end) report("page_end", want.page_end, got.page_end);
      if (got.status !== want.status) report("status", want.status, got.status);
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  byte_label_tracker tracker;
  int unsigned       items_sent = 0;

  btree_page_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  // Offer one byte, optionally after a random gap; returns at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic l, input bit steady);
    int unsigned r;
    int unsigned gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!steady) begin
      if (r >= 92) gap = $urandom_range(8, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= l;
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    @(posedge clk_i);
    tracker.note_byte(b, l);
    items_sent++;
  endtask

  task automatic send_page(input page_t pg, input bit steady);
    for (int i = 0; i < pg.size(); i++) send_byte(pg[i], i == pg.size() - 1, steady);
  endtask

  // Mostly well-formed pages with random content; some noise, corrupt or cut pages
  function automatic page_t make_page(bit long_key);
    page_t       pg;
    int unsigned n;
    int unsigned len;
    int unsigned pick;
    bit          leaf;
    bit          root;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 8)) pg.push_back(8'($urandom));
      return pg;
    end
    for (int i = 0; i < MagicLen; i++) pg.push_back(MAGIC_BYTES[i]);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
    pg.push_back(8'(n >> 8));
    pg.push_back(8'(n));
    leaf = $urandom_range(0, 1);
    root = $urandom_range(0, 1);
    pg.push_back({root, leaf ? 7'd0 : 7'($urandom_range(1, 127))});
    pg.push_back(8'($urandom));
    if (root) repeat (TsizeLen) pg.push_back(8'($urandom));
    for (int k = 0; k < n; k++) begin
      len = (long_key && k == 0) ? 255 : $urandom_range(0, 5);
      pg.push_back(8'(len));
      repeat (len) pg.push_back(8'($urandom));
    end
    if (leaf) begin
      for (int k = 0; k < n; k++) begin
        len = $urandom_range(0, 5);
        pg.push_back(8'(len));
        repeat (len) pg.push_back(8'($urandom));
      end
    end else begin
      repeat ((n + 1) * ChildLen) pg.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 5)) pg.push_back(8'h00);
    if (long_key) return pg;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      len     = $urandom_range(0, MagicLen - 1);
      pg[len] = pg[len] ^ 8'(1 << $urandom_range(0, 7));
    end else if (pick < 25) begin
      len = $urandom_range(1, pg.size());
      while (pg.size() > len) void'(pg.pop_back());
    end else if (pick < 35) begin
      pg.push_back(8'($urandom_range(1, 255)));
      repeat ($urandom_range(0, 2)) pg.push_back(8'h00);
    end
    return pg;
  endfunction

  // Output side: random stalls, ready runs, and one long hold-off
  initial begin
    int unsigned cyc;
    int unsigned len;
    int unsigned r;
    bit          held;
    cyc  = 0;
    held = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (!held && cyc >= HoldStart) begin
        held = 1'b1;
        len  = HoldLen;
        m_axis_tready_i <= 1'b0;
      end else if (r < 45) begin
        len = $urandom_range(1, 20);
        m_axis_tready_i <= 1'b1;
      end else begin
        len = (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        m_axis_tready_i <= 1'b0;
      end
      repeat (len) @(posedge clk_i);
      cyc += len;
    end
  end

  // Items are checked at the falling edge before the edge that takes them
  always @(negedge clk_i) begin
    label_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind        = kind_e'(m_axis_tuser_o);
      got.elem_index  = m_axis_tdata_o[15:0];
      got.elem_offset = m_axis_tdata_o[23:16];
      got.data_byte   = m_axis_tdata_o[31:24];
      got.status      = status_e'(m_axis_tdata_o[33:32]);
      got.page_end    = m_axis_tlast_o;
      tracker.check_label(got);
    end
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    page_t pg;
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bad magic, then the rest of the page is padding
    pg = '{8'h4B, 8'h57, 8'h00};
    send_page(pg, 1'b0);
    // root page with full key count, cut inside the tree size
    pg = '{8'h4B, 8'h56, 8'h4C, 8'h44, 8'h53, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00,
           8'hA5, 8'h5A};
    send_page(pg, 1'b0);
    // parent page cut at the prefix length
    pg = '{8'h4B, 8'h56, 8'h4C, 8'h44, 8'h53, 8'h00, 8'h00, 8'h01, 8'h01, 8'h7F};
    send_page(pg, 1'b0);

    send_page(make_page(1'b1), 1'b0);
    while (items_sent < ItemTarget) send_page(make_page(1'b0), $urandom_range(0, 3) == 0);
    s_axis_tvalid_i <= 1'b0;

    while (tracker.labels_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
